// File: hdl/mme_pkg.sv
// shared types, constants and a helper function of the matrix multiply engine
// depends on nothing; used by every other file of the block
package mme_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;

   localparam int DATA_W = 32;
   localparam int CSR_W  = 4;
   localparam int IDX_W  = 3;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int CNT_W  = $clog2(2 * MAX_DIM * MAX_DIM);
   localparam int TOT_W  = CNT_W + 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(MAX_DIM);

   localparam logic [CSR_W-1:0] DIM_RESET = CSR_W'(4);

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // register indexes of the configuration port
   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WAIT,
      ST_ISSUE
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] product_value;
      logic [IDX_W-1:0]         out_row;
      logic [IDX_W-1:0]         out_col;
      logic                     last_element;
      logic                     saturated;
   } rsp_payload_type;

   // per-read tag that travels down the datapath pipeline
   typedef struct packed {
      logic             first;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_elem;
   } tag_type;

   typedef struct packed {
      logic              wr_en;
      logic              wr_sel_b;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] a_addr;
      logic [ADDR_W-1:0] b_addr;
      tag_type           tag;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CSR_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (32'(r) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

endpackage

// File: hdl/mme_if.sv
// valid/ready channel interfaces for the request and response sides
// depends on mme_pkg for the payload types
interface mme_req_if;
   logic                     valid;
   logic                     ready;
   mme_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mme_rsp_if;
   logic                     valid;
   logic                     ready;
   mme_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/mme_ctrl.sv
// controller: configuration registers, load counter and the product sequencer
// depends on mme_pkg; drives the datapath through cmd_type, reads status_type
module mme_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [mme_pkg::CSR_W-1:0] csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   output mme_pkg::cmd_type     cmd,
   input  mme_pkg::status_type  status
);

   localparam int DIM_W  = mme_pkg::DIM_W;
   localparam int ADDR_W = mme_pkg::ADDR_W;
   localparam int TOT_W  = mme_pkg::TOT_W;
   localparam int CNT_W  = mme_pkg::CNT_W;
   localparam int IDX_W  = mme_pkg::IDX_W;

   logic [mme_pkg::CSR_W-1:0] rows_ff, inner_ff, cols_ff;

   mme_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ADDR_W-1:0]  base_ff, base_in, a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;

   logic [DIM_W-1:0] m, n, p;
   logic [TOT_W-1:0] size_a, total, pos, next_pos, b_off;
   logic             in_a, last_k, last_j, last_elem;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mme_pkg::DIM_RESET;
         inner_ff <= mme_pkg::DIM_RESET;
         cols_ff  <= mme_pkg::DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mme_pkg::CSR_ROWS_A:    rows_ff  <= csr_data;
            mme_pkg::CSR_INNER_DIM: inner_ff <= csr_data;
            mme_pkg::CSR_COLS_B:    cols_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign m = mme_pkg::eff_dim(rows_ff);
   assign n = mme_pkg::eff_dim(inner_ff);
   assign p = mme_pkg::eff_dim(cols_ff);

   assign size_a   = TOT_W'(m) * TOT_W'(n);
   assign total    = size_a + TOT_W'(n) * TOT_W'(p);
   assign pos      = TOT_W'(count_ff);
   assign next_pos = pos + TOT_W'(1);
   assign in_a     = pos < size_a;
   assign b_off    = pos - size_a;

   assign last_k    = DIM_W'(k_ff) == n - DIM_W'(1);
   assign last_j    = DIM_W'(j_ff) == p - DIM_W'(1);
   assign last_elem = (DIM_W'(i_ff) == m - DIM_W'(1)) && last_j;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      base_ff   <= base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      base_in   = base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      req_ready = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         mme_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel_b = !in_a;
               cmd.wr_addr  = in_a ? pos[ADDR_W-1:0] : b_off[ADDR_W-1:0];
               if (next_pos == total) begin
                  // matrix b complete: start the product at element (0,0)
                  count_in  = '0;
                  i_in      = '0;
                  j_in      = '0;
                  k_in      = '0;
                  base_in   = '0;
                  a_addr_in = '0;
                  b_addr_in = '0;
                  state_in  = mme_pkg::ST_WAIT;
               end else begin
                  count_in = next_pos[CNT_W-1:0];
               end
            end
         end
         mme_pkg::ST_WAIT: begin
            if (!status.busy) begin
               state_in = mme_pkg::ST_ISSUE;
            end
         end
         mme_pkg::ST_ISSUE: begin
            cmd.rd_en         = 1'b1;
            cmd.a_addr        = a_addr_ff;
            cmd.b_addr        = b_addr_ff;
            cmd.tag.first     = k_ff == '0;
            cmd.tag.last      = last_k;
            cmd.tag.row       = i_ff;
            cmd.tag.col       = j_ff;
            cmd.tag.last_elem = last_elem;
            if (!last_k) begin
               k_in      = k_ff + IDX_W'(1);
               a_addr_in = a_addr_ff + ADDR_W'(1);
               b_addr_in = b_addr_ff + ADDR_W'(p);
            end else begin
               k_in = '0;
               if (last_j) begin
                  j_in      = '0;
                  i_in      = i_ff + IDX_W'(1);
                  base_in   = base_ff + ADDR_W'(n);
                  a_addr_in = base_ff + ADDR_W'(n);
                  b_addr_in = '0;
               end else begin
                  j_in      = j_ff + IDX_W'(1);
                  a_addr_in = base_ff;
                  b_addr_in = ADDR_W'(j_ff) + ADDR_W'(1);
               end
               state_in = last_elem ? mme_pkg::ST_LOAD : mme_pkg::ST_WAIT;
            end
         end
         default: state_in = mme_pkg::ST_LOAD;
      endcase

      // any register write abandons a partial load
      if (csr_wr_en) begin
         count_in = '0;
      end
   end

endmodule

// File: hdl/mme_datapath.sv
// datapath: matrix stores, multiply-accumulate pipeline, saturation and output stage
// depends on mme_pkg; commanded by mme_ctrl
module mme_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  mme_pkg::cmd_type                cmd,
   output mme_pkg::status_type             status,
   input  logic [mme_pkg::DATA_W-1:0]      wr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mme_pkg::rsp_payload_type        rsp_payload
);

   localparam int DATA_W = mme_pkg::DATA_W;
   localparam int ACC_W  = mme_pkg::ACC_W;
   localparam int DEPTH  = mme_pkg::MAX_DIM * mme_pkg::MAX_DIM;

   logic [DATA_W-1:0] store_a [DEPTH];
   logic [DATA_W-1:0] store_b [DEPTH];

   logic [DATA_W-1:0]               rd_a_ff, rd_b_ff;
   logic                            s1_valid_ff, s2_valid_ff, done_ff, hold_valid_ff, out_valid_ff;
   mme_pkg::tag_type                s1_tag_ff, s2_tag_ff, done_tag_ff;
   logic signed [mme_pkg::PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]         acc_ff, acc_in, shifted;
   mme_pkg::rsp_payload_type        hold_ff, hold_in, out_ff;
   logic                            in_range, out_free;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_sel_b) begin
         store_a[cmd.wr_addr] <= wr_data;
      end
      if (cmd.wr_en && cmd.wr_sel_b) begin
         store_b[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= store_a[cmd.a_addr];
         rd_b_ff <= store_b[cmd.b_addr];
      end
   end

   // floor shift of the exact product, sign extended to the accumulator
   assign shifted = ACC_W'(prod_ff >>> mme_pkg::FRAC_BITS);
   assign acc_in  = s2_tag_ff.first ? shifted : acc_ff + shifted;

   // sum fits when every bit above the data sign bit matches it
   assign in_range = (&acc_ff[ACC_W-1:DATA_W-1]) || !(|acc_ff[ACC_W-1:DATA_W-1]);

   always_comb begin
      hold_in.out_row      = done_tag_ff.row;
      hold_in.out_col      = done_tag_ff.col;
      hold_in.last_element = done_tag_ff.last_elem;
      hold_in.saturated    = !in_range;
      if (in_range) begin
         hold_in.product_value = acc_ff[DATA_W-1:0];
      end else begin
         hold_in.product_value = acc_ff[ACC_W-1] ? mme_pkg::DATA_MIN : mme_pkg::DATA_MAX;
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         done_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_tag_ff.last;
         if (done_ff) begin
            hold_valid_ff <= 1'b1;
         end else if (out_free) begin
            hold_valid_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= hold_valid_ff;
         end
      end
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= $signed(rd_a_ff) * $signed(rd_b_ff);
      if (s2_valid_ff) begin
         acc_ff      <= acc_in;
         done_tag_ff <= s2_tag_ff;
      end
      if (done_ff) begin
         hold_ff <= hold_in;
      end
      if (out_free && hold_valid_ff) begin
         out_ff <= hold_ff;
      end
   end

   assign status.busy = s1_valid_ff || s2_valid_ff || done_ff || hold_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// File: hdl/matrix_multiply_engine_top.sv
// matrix multiply engine top level: channel ports, controller and datapath
// depends on mme_pkg, mme_if, mme_ctrl and mme_datapath
//
// Loads matrix A (rows_a x inner_dim) and then matrix B (inner_dim x cols_b), one signed
// Q16.16 element per request transaction in row-major order, then streams out C = A*B in
// row-major order with row, column, a last-element flag and a saturation flag. Each product
// is formed exactly, shifted right by 16 (toward minus infinity) and summed exactly; the sum
// saturates to 32 bits. Load transactions are taken one per cycle. The transaction that
// completes B starts the product, and no request is taken until every read for C has been
// issued. One multiply-accumulate unit fed by one read port on each store computes one
// element at a time: it issues inner_dim reads for the element, then waits until the
// pipeline has drained and the result has moved to the output register before the next.
// Registers read 0 as 1 and anything above 8 as 8; any register write abandons a partial
// load. Write registers only while the block is idle. After reset the stores hold garbage,
// which is never read since every product only reads elements loaded in the same pass.
module matrix_multiply_engine_top (
   input  logic                      clock,
   input  logic                      reset,
   mme_req_if.sink                   req_chan,
   mme_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [mme_pkg::CSR_W-1:0] csr_data
);

   mme_pkg::cmd_type    cmd;
   mme_pkg::status_type status;

   // sequencer: register file, load count and product loop counters
   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // stores, mac pipeline and response register
   mme_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .wr_data     (req_chan.payload.element_value),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

// File: hdl/mme_checker.sv
// port-level checks of the matrix multiply engine, bound to the top level
// depends on mme_pkg and matrix_multiply_engine_top
module mme_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mme_pkg::rsp_payload_type rsp_payload
);

   // a stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // a clipped sum shows only one of the two range limits
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.saturated |->
         rsp_payload.product_value == mme_pkg::DATA_MAX ||
         rsp_payload.product_value == mme_pkg::DATA_MIN)
      else $error("saturated flag with unclipped value");

   // after reset the block is loading and has no result pending
   a_reset_load: assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // reset withdraws any response transaction that is on offer
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid out of reset");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
